>>> rtl/margin_gradient_alpha_compositor_unit_assert.svh
// Assertion helpers for the compositor.
`ifndef MARGIN_GRADIENT_ALPHA_COMPOSITOR_UNIT_ASSERT_SVH
`define MARGIN_GRADIENT_ALPHA_COMPOSITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MGAC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mgac assertion failed");

// Next-cycle implication, disabled in reset.
`define MGAC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mgac assertion failed");

`endif

>>> rtl/mgac_pkg.sv
`default_nettype none
package mgac_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int SQRT_STEPS = 3;
   localparam int SQRT_STAGES = 3;
   localparam int DIV_STEPS = 2;
   localparam int DIV_STAGES = 4;

   localparam logic [7:0] BYTE_MAX = 8'hff;

   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_FRAME_WIDTH = 3'd0;
   localparam csr_index_type CSR_FRAME_HEIGHT = 3'd1;
   localparam csr_index_type CSR_MARGIN_SIZE = 3'd2;
   localparam csr_index_type CSR_GRADIENT_WIDTH = 3'd3;
   localparam csr_index_type CSR_BACKGROUND_TINT = 3'd4;

   typedef enum logic [1:0] {
      KIND_PASS = 2'd0,
      KIND_BOX = 2'd1,
      KIND_LINE = 2'd2,
      KIND_CORNER = 2'd3
   } kind_type;

   typedef struct packed {
      logic [13:0] frame_width;
      logic [13:0] frame_height;
      logic [11:0] margin_size;
      logic [7:0] gradient_width;
      logic [31:0] background_tint;
   } cfg_type;

   typedef struct packed {
      kind_type kind;
      logic [7:0] dx;
      logic [7:0] dy;
      logic [31:0] px;
   } entry_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic [11:0] rem;
      logic [8:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [8:0] rem;
      logic [7:0] quo;
   } div_type;

   // One radix-4 digit of the integer square root
   function automatic sqrt_type sqrt_step(input sqrt_type cur, input logic [1:0] bits);
      sqrt_type nxt;
      logic [11:0] r2;
      logic [11:0] t;
      r2 = {cur.rem[9:0], bits};
      t = {1'b0, cur.root, 2'b01};
      if (r2 >= t) begin
         nxt.rem = r2 - t;
         nxt.root = {cur.root[7:0], 1'b1};
      end else begin
         nxt.rem = r2;
         nxt.root = {cur.root[7:0], 1'b0};
      end
      return nxt;
   endfunction

   // One restoring step of an 8-bit division
   function automatic div_type div_step(input div_type cur, input logic [7:0] den);
      div_type nxt;
      logic [8:0] r;
      r = {cur.rem[7:0], cur.quo[7]};
      nxt.quo = {cur.quo[6:0], 1'b0};
      if (r >= {1'b0, den}) begin
         nxt.rem = r - {1'b0, den};
         nxt.quo[0] = 1'b1;
      end else begin
         nxt.rem = r;
      end
      return nxt;
   endfunction

endpackage
`default_nettype wire

>>> rtl/mgac_if.sv
`default_nettype none
interface mgac_req_if #(parameter int COORD_BITS = 13) ();
   logic valid;
   logic ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [31:0] source_pixel;
   modport source (output valid, pixel_x, pixel_y, source_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, source_pixel, output ready);
endinterface

interface mgac_rsp_if ();
   logic valid;
   logic ready;
   logic [31:0] canvas_pixel;
   modport source (output valid, canvas_pixel, input ready);
   modport sink (input valid, canvas_pixel, output ready);
endinterface

interface mgac_csr_if ();
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/mgac_front.sv
`default_nettype none
module mgac_front import mgac_pkg::*; #(
   parameter int COORD_BITS = 13
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [COORD_BITS-1:0] pixel_x,
   input wire logic [COORD_BITS-1:0] pixel_y,
   input wire logic [31:0] source_pixel,
   input wire cfg_type cfg,
   input wire logic fifo_full,
   output logic push,
   output entry_type entry
);

   localparam int SW = ((COORD_BITS > 14) ? COORD_BITS : 14) + 2;

   logic signed [SW-1:0] xs, ys, ws, hs, ms, gs, mng_raw, mng;
   logic signed [SW-1:0] sx, sy, gx, gy, dxs, dys;
   logic in_xb, in_yb, outside, box, rx, r1, r2, r3, r4, ring;
   logic dx_far, dy_far;
   logic [7:0] dx8, dy8;
   logic valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic accept;

   assign xs = signed'(SW'(pixel_x));
   assign ys = signed'(SW'(pixel_y));
   assign ws = signed'(SW'(cfg.frame_width));
   assign hs = signed'(SW'(cfg.frame_height));
   assign ms = signed'(SW'(cfg.margin_size));
   assign gs = signed'(SW'(cfg.gradient_width));

   // region bounds
   assign mng_raw = ms - gs;
   assign mng = (mng_raw < 0) ? '0 : mng_raw;
   assign sx = ws - mng;
   assign sy = hs - mng;
   assign gx = ws - ms;
   assign gy = hs - ms;

   // classify the pixel
   assign in_xb = (xs >= ms) && (xs < gx);
   assign in_yb = (ys >= ms) && (ys < gy);
   assign outside = (xs >= ws) || (ys >= hs);
   assign box = in_xb && in_yb;
   assign rx = (xs >= mng) && (xs < sx);
   assign r1 = rx && (ys >= mng) && (ys < ms);
   assign r2 = rx && (ys >= gy) && (ys < sy);
   assign r3 = (xs >= mng) && (xs < ms) && in_yb;
   assign r4 = (xs >= gx) && (xs < sx) && in_yb;
   assign ring = (cfg.gradient_width != '0) && (r1 || r2 || r3 || r4);

   // axis distances to the box, out-of-range taken as far
   assign dxs = (xs < ms) ? (ms - xs) : (xs - gx);
   assign dys = (ys < ms) ? (ms - ys) : (ys - gy);
   assign dx_far = (dxs < 0) || (dxs > signed'(SW'(BYTE_MAX)));
   assign dy_far = (dys < 0) || (dys > signed'(SW'(BYTE_MAX)));
   assign dx8 = dxs[7:0];
   assign dy8 = dys[7:0];

   always_comb begin
      entry_in.px = source_pixel;
      entry_in.dx = dx8;
      entry_in.dy = dy8;
      entry_in.kind = KIND_PASS;
      if (outside) begin
         entry_in.kind = KIND_PASS;
      end else if (box) begin
         entry_in.kind = KIND_BOX;
      end else if (ring) begin
         if (in_xb) begin
            entry_in.dx = dy8;
            entry_in.kind = (dy_far || (dy8 > cfg.gradient_width)) ? KIND_PASS : KIND_LINE;
         end else if (in_yb) begin
            entry_in.kind = (dx_far || (dx8 > cfg.gradient_width)) ? KIND_PASS : KIND_LINE;
         end else begin
            entry_in.kind = (dx_far || dy_far) ? KIND_PASS : KIND_CORNER;
         end
      end
   end

   // hold one classified word until the queue takes it
   assign push = valid_ff && !fifo_full;
   assign req_ready = !valid_ff || !fifo_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

>>> rtl/mgac_fifo.sv
`default_nettype none
module mgac_fifo import mgac_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire entry_type push_entry,
   input wire logic pop,
   output logic pop_valid,
   output entry_type pop_entry,
   output fifo_stat_type stat
);

   entry_type mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign do_pop = pop && (count_ff != '0);

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_valid = (count_ff != '0);
   assign pop_entry = mem_ff[rd_ptr_ff];
   assign stat.count = count_ff;
   assign stat.full = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule
`default_nettype wire

>>> rtl/mgac_back.sv
`default_nettype none
module mgac_back import mgac_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic fifo_valid,
   input wire entry_type fifo_entry,
   output logic pop,
   input wire cfg_type cfg,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [31:0] canvas_pixel
);

   logic en;
   logic [7:0] ta, step;

   // square root pipeline: index 0 holds the sum of squares
   logic v_ff [SQRT_STAGES+1];
   kind_type kind_ff [SQRT_STAGES+1];
   logic [7:0] d_ff [SQRT_STAGES+1];
   logic [31:0] px_ff [SQRT_STAGES+1];
   logic [17:0] sq_ff [SQRT_STAGES+1];
   sqrt_type sr_ff [SQRT_STAGES+1];
   sqrt_type sr_in [SQRT_STAGES+1];
   logic [15:0] sq_a, sq_b;

   // alpha stage
   logic v5_ff, blend5_ff, blend5_in;
   logic [7:0] na5_ff, na5_in;
   logic [31:0] px5_ff;
   logic [8:0] dist_val;
   logic [16:0] prod;

   // output register
   logic rsp_valid_ff;
   logic [31:0] out_ff, out_in;
   logic [7:0] wf;
   logic [8:0] wb;
   logic [17:0] acc [3];

   // step divider over configuration
   div_type dv_ff [DIV_STAGES+1];
   div_type dv_in [DIV_STAGES+1];

   assign ta = cfg.background_tint[31:24];
   assign en = !rsp_valid_ff || rsp_ready;
   assign pop = en && fifo_valid;

   // free-running divider: (255 - tint alpha) / gradient width
   always_comb begin
      dv_in[0].rem = '0;
      dv_in[0].quo = BYTE_MAX - ta;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         dv_in[s] = dv_ff[s-1];
         for (int k = 0; k < DIV_STEPS; k++) begin
            dv_in[s] = div_step(dv_in[s], cfg.gradient_width);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_STAGES; s++) begin
         dv_ff[s] <= dv_in[s];
      end
   end

   assign step = dv_ff[DIV_STAGES].quo;

   // sum of squares
   assign sq_a = fifo_entry.dx * fifo_entry.dx;
   assign sq_b = fifo_entry.dy * fifo_entry.dy;

   // root digits, three per stage
   always_comb begin
      sr_in[0] = '0;
      for (int s = 1; s <= SQRT_STAGES; s++) begin
         sr_in[s] = sr_ff[s-1];
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sr_in[s] = sqrt_step(sr_in[s],
               sq_ff[s-1][2*(SQRT_STAGES*SQRT_STEPS-1-(s-1)*SQRT_STEPS-k) +: 2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= SQRT_STAGES; s++) begin
            v_ff[s] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= fifo_valid;
         for (int s = 1; s <= SQRT_STAGES; s++) begin
            v_ff[s] <= v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_ff[0] <= fifo_entry.kind;
         d_ff[0] <= fifo_entry.dx;
         px_ff[0] <= fifo_entry.px;
         sq_ff[0] <= 18'(sq_a) + 18'(sq_b);
         sr_ff[0] <= sr_in[0];
         for (int s = 1; s <= SQRT_STAGES; s++) begin
            kind_ff[s] <= kind_ff[s-1];
            d_ff[s] <= d_ff[s-1];
            px_ff[s] <= px_ff[s-1];
            sq_ff[s] <= sq_ff[s-1];
            sr_ff[s] <= sr_in[s];
         end
      end
   end

   // pick distance and form the blend alpha
   assign dist_val = (kind_ff[SQRT_STAGES] == KIND_CORNER) ? sr_ff[SQRT_STAGES].root
                                                           : {1'b0, d_ff[SQRT_STAGES]};
   assign prod = step * dist_val;

   always_comb begin
      case (kind_ff[SQRT_STAGES])
         KIND_BOX: begin
            blend5_in = 1'b1;
            na5_in = ta;
         end
         KIND_LINE, KIND_CORNER: begin
            blend5_in = (dist_val <= {1'b0, cfg.gradient_width});
            na5_in = ta + prod[7:0];
         end
         default: begin
            blend5_in = 1'b0;
            na5_in = ta;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v_ff[SQRT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         blend5_ff <= blend5_in;
         na5_ff <= na5_in;
         px5_ff <= px_ff[SQRT_STAGES];
      end
   end

   // blend each color channel
   assign wf = BYTE_MAX - na5_ff;
   assign wb = {1'b0, na5_ff} + 9'd1;

   always_comb begin
      out_in = px5_ff;
      for (int c = 0; c < 3; c++) begin
         acc[c] = 18'(wf) * 18'(cfg.background_tint[8*c +: 8])
                  + 18'(wb) * 18'(px5_ff[8*c +: 8]);
      end
      if (blend5_ff) begin
         out_in = {8'h00, acc[2][15:8], acc[1][15:8], acc[0][15:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign canvas_pixel = out_ff;

endmodule
`default_nettype wire

>>> rtl/margin_gradient_alpha_compositor_unit.sv
// A req word passes the front register, the queue, the root, alpha and output stages.
// Throughput: one pixel per cycle; a stalled rsp holds the root and alpha pipeline.
// The tint step divider settles once a configuration write has passed all its stages.
// Reset (synchronous, active high) clears the pipeline and queue and sets the
// configuration registers to 1024 x 768, margin 64, gradient 4, tint 0x80000000.
`default_nettype none
`include "margin_gradient_alpha_compositor_unit_assert.svh"
module margin_gradient_alpha_compositor_unit import mgac_pkg::*; #(
   parameter int COORD_BITS = 13
) (
   input wire logic clock,
   input wire logic reset,
   mgac_req_if.sink req_if,
   mgac_rsp_if.source rsp_if,
   mgac_csr_if.sink csr_if
);

   cfg_type cfg_ff, cfg_in;
   logic csr_write;
   logic front_push;
   entry_type front_entry;
   logic fifo_valid, back_pop;
   entry_type fifo_entry;
   fifo_stat_type fifo_stat;

   // configuration registers
   assign csr_if.ready = 1'b1;
   assign csr_write = csr_if.valid && csr_if.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_if.index)
            CSR_FRAME_WIDTH: cfg_in.frame_width = csr_if.data[13:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_if.data[13:0];
            CSR_MARGIN_SIZE: cfg_in.margin_size = csr_if.data[11:0];
            CSR_GRADIENT_WIDTH: cfg_in.gradient_width = csr_if.data[7:0];
            CSR_BACKGROUND_TINT: cfg_in.background_tint = csr_if.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width <= 14'd1024;
         cfg_ff.frame_height <= 14'd768;
         cfg_ff.margin_size <= 12'd64;
         cfg_ff.gradient_width <= 8'd4;
         cfg_ff.background_tint <= 32'h8000_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mgac_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_if.ready),
      .pixel_x(req_if.pixel_x),
      .pixel_y(req_if.pixel_y),
      .source_pixel(req_if.source_pixel),
      .cfg(cfg_ff),
      .fifo_full(fifo_stat.full),
      .push(front_push),
      .entry(front_entry)
   );

   mgac_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(front_push),
      .push_entry(front_entry),
      .pop(back_pop),
      .pop_valid(fifo_valid),
      .pop_entry(fifo_entry),
      .stat(fifo_stat)
   );

   mgac_back u_back (
      .clock(clock),
      .reset(reset),
      .fifo_valid(fifo_valid),
      .fifo_entry(fifo_entry),
      .pop(back_pop),
      .cfg(cfg_ff),
      .rsp_valid(rsp_if.valid),
      .rsp_ready(rsp_if.ready),
      .canvas_pixel(rsp_if.canvas_pixel)
   );

   `MGAC_ASSERT_NOW(a_fifo_bound, clock, reset, 1'b1, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH))
   `MGAC_ASSERT_NOW(a_no_ring, clock, reset, front_push && (cfg_ff.gradient_width == 8'd0), front_entry.kind == KIND_PASS || front_entry.kind == KIND_BOX)
   `MGAC_ASSERT_NEXT(a_csr_ignore, clock, reset, csr_write && (csr_if.index > CSR_BACKGROUND_TINT), $stable(cfg_ff))

endmodule
`default_nettype wire
